### hw/rtl/ssi_pkg.sv
// Shared widths, field offsets, codes and the round/saturate helper for the
// stereo space intersection pipeline. No dependencies.
`timescale 1ns / 1ps

package ssi_pkg;

    localparam int V_W           = 48;   // Q24.24 value word
    localparam int P_W           = 2 * V_W;
    localparam int ACC_W         = P_W + 4;
    localparam int PIX_W         = 32;
    localparam int PIX_FRAC      = 16;
    localparam int DIM_W         = 16;
    localparam int CEN_W         = PIX_W + 1;
    localparam int FRAC_BITS_DEF = 24;
    localparam int TBL_DEPTH     = 12;
    localparam int IDX_W         = 4;
    localparam int CFG_IDX_W     = 3;
    localparam int DIV_LAT       = V_W + 5;

    localparam int OFF_IDX  = 0;
    localparam int OFF_COEF = OFF_IDX + IDX_W;
    localparam int OFF_LPX  = OFF_COEF + V_W;
    localparam int OFF_LPY  = OFF_LPX + PIX_W;
    localparam int OFF_RPX  = OFF_LPY + PIX_W;
    localparam int OFF_RPY  = OFF_RPX + PIX_W;
    localparam int S_DATA_W = ((OFF_RPY + PIX_W + 7) / 8) * 8;
    localparam int M_DATA_W = 3 * V_W;

    typedef logic signed [V_W-1:0]   val_t;
    typedef logic signed [P_W-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0] acc_t;

    typedef enum logic [0:0] {
        OP_LOAD  = 1'b0,
        OP_SOLVE = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOCAL = 3'd0,
        REG_PIXEL = 3'd1,
        REG_COLS  = 3'd2,
        REG_ROWS  = 3'd3,
        REG_CX    = 3'd4,
        REG_CY    = 3'd5,
        REG_CZ    = 3'd6
    } cfg_reg_t;

    localparam val_t VAL_MAX = {1'b0, {(V_W-1){1'b1}}};
    localparam val_t VAL_MIN = {1'b1, {(V_W-1){1'b0}}};

    // round to nearest (ties up) at bit s, then clamp to the value word
    function automatic val_t rnd_sat(input acc_t w, input int unsigned s);
        acc_t h;
        acc_t t;
        h = '0;
        h[s-1] = 1'b1;
        t = (w + h) >>> s;
        if ((&t[ACC_W-1:V_W-1]) || !(|t[ACC_W-1:V_W-1]))
            return t[V_W-1:0];
        return t[ACC_W-1] ? VAL_MIN : VAL_MAX;
    endfunction

endpackage

### hw/rtl/ssi_mul.sv
// Two-stage signed 48x48 multiplier: four 25x25 partial products, then sum.
// Depends on ssi_pkg.
`timescale 1ns / 1ps

module ssi_mul (
    input  logic          aclk,
    input  logic          en,
    input  ssi_pkg::val_t a,
    input  ssi_pkg::val_t b,
    output ssi_pkg::prod_t p
);
    localparam int H = ssi_pkg::V_W / 2;

    logic signed [H:0]     al, ah, bl, bh;
    logic signed [2*H+1:0] ll_reg, lh_reg, hl_reg, hh_reg;
    ssi_pkg::prod_t        p_next, p_reg;

    assign al = {1'b0, a[H-1:0]};
    assign ah = {a[ssi_pkg::V_W-1], a[ssi_pkg::V_W-1:H]};
    assign bl = {1'b0, b[H-1:0]};
    assign bh = {b[ssi_pkg::V_W-1], b[ssi_pkg::V_W-1:H]};

    assign p_next = (ssi_pkg::prod_t'(hh_reg) <<< (2*H))
                  + (ssi_pkg::prod_t'(lh_reg) <<< H)
                  + (ssi_pkg::prod_t'(hl_reg) <<< H)
                  + ssi_pkg::prod_t'(ll_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg <= al * bl;
            lh_reg <= al * bh;
            hl_reg <= ah * bl;
            hh_reg <= ah * bh;
            p_reg  <= p_next;
        end
    end

    assign p = p_reg;
endmodule

### hw/rtl/ssi_dly.sv
// Enabled delay line that carries payload alongside the pipeline stages.
// No package dependencies.
`timescale 1ns / 1ps

module ssi_dly #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);
    logic [W-1:0] sr_reg [N];

    always_ff @(posedge aclk) begin
        if (en) begin
            sr_reg[0] <= d;
            for (int i = 1; i < N; i++)
                sr_reg[i] <= sr_reg[i-1];
        end
    end

    assign q = sr_reg[N-1];
endmodule

### hw/rtl/ssi_div.sv
// Pipelined signed divide, rounded half away from zero and saturated to 48 bits.
// One quotient bit per stage. Depends on ssi_pkg.
`timescale 1ns / 1ps

module ssi_div (
    input  logic          aclk,
    input  logic          en,
    input  ssi_pkg::acc_t num,
    input  ssi_pkg::val_t den,
    output ssi_pkg::val_t quo
);
    localparam int V = ssi_pkg::V_W;
    localparam int A = ssi_pkg::ACC_W;

    logic [A-1:0] nm0_next, nm0_reg, nm1_reg;
    logic [V-1:0] d0_next, d0_reg, d1_reg;
    logic         neg0_reg, neg1_reg;

    logic [V-1:0] rem_reg [V];
    logic [V-1:0] d_reg   [V];
    logic [V-1:0] w_reg   [V+1];
    logic         neg_reg [V+1];
    logic         ovf_reg [V+1];
    logic [V-1:0] rem_next [V-1];
    logic [V-1:0] w_next   [V];
    logic         ge_c     [V];

    logic [V-1:0]  lim, qs_reg;
    logic          negs_reg;
    ssi_pkg::val_t quo_reg;

    assign nm0_next = num[A-1] ? $unsigned(-num) : $unsigned(num);
    assign d0_next  = den[V-1] ? $unsigned(-den) : $unsigned(den);

    always_comb begin
        logic [V:0] tr;
        for (int k = 0; k < V; k++) begin
            tr = {rem_reg[k], w_reg[k][V-1]};
            ge_c[k] = tr >= {1'b0, d_reg[k]};
            w_next[k] = {w_reg[k][V-2:0], ge_c[k]};
        end
        for (int k = 0; k < V - 1; k++) begin
            tr = {rem_reg[k], w_reg[k][V-1]};
            rem_next[k] = ge_c[k] ? V'(tr - {1'b0, d_reg[k]}) : tr[V-1:0];
        end
    end

    assign lim = neg_reg[V] ? {1'b1, {(V-1){1'b0}}} : {1'b0, {(V-1){1'b1}}};

    always_ff @(posedge aclk) begin
        if (en) begin
            nm0_reg  <= nm0_next;
            d0_reg   <= d0_next;
            neg0_reg <= num[A-1] ^ den[V-1];
            nm1_reg  <= nm0_reg + A'(d0_reg >> 1);
            d1_reg   <= d0_reg;
            neg1_reg <= neg0_reg;
            // quotient of 2^48 or more always clamps
            ovf_reg[0] <= nm1_reg[A-1:V] >= (A-V)'(d1_reg);
            rem_reg[0] <= nm1_reg[2*V-1:V];
            w_reg[0]   <= nm1_reg[V-1:0];
            d_reg[0]   <= d1_reg;
            neg_reg[0] <= neg1_reg;
            for (int k = 0; k < V - 1; k++) begin
                rem_reg[k+1] <= rem_next[k];
                d_reg[k+1]   <= d_reg[k];
            end
            for (int k = 0; k < V; k++) begin
                w_reg[k+1]   <= w_next[k];
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
            qs_reg   <= (ovf_reg[V] || (w_reg[V] > lim)) ? lim : w_reg[V];
            negs_reg <= neg_reg[V];
            quo_reg  <= negs_reg ? ssi_pkg::val_t'(V'(0) - qs_reg)
                                 : ssi_pkg::val_t'(qs_reg);
        end
    end

    assign quo = quo_reg;
endmodule

### hw/rtl/stereo_space_intersection.sv
// Stereo space intersection: least-squares triangulation of matched pixel pairs.
// Top level; depends on ssi_pkg, ssi_mul, ssi_dly and ssi_div.
//
// The block takes one item per clock while no result is held on m_, and returns
// one ground point per point-pair item, in order. The path is a fixed pipeline:
// pixel centring, the four collinearity rows, the 3x3 normal matrix, cofactors,
// determinant and numerators (each a multiply level of four register stages,
// 48x48 products built from 25x25 partial products over two stages), then a
// divider that resolves one quotient bit per stage (53 stages). A held result
// on m_ stalls the whole pipeline, so s_tready follows !m_tvalid || m_tready.
// Load items (tuser 0) write one projection table word when they reach the
// fourth stage and produce no result; later point pairs see the new word.
// Configuration writes are taken at any time with cfg_ready high, but belong
// to idle periods only.
`timescale 1ns / 1ps

module stereo_space_intersection #(
    parameter int FRAC_BITS = ssi_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // coef_index, coef_value, left_px, left_py, right_px, right_py, zero pad
    input  logic [ssi_pkg::S_DATA_W-1:0]   s_tdata,
    // opcode
    input  logic [0:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // ground_x, ground_y, ground_z
    output logic [ssi_pkg::M_DATA_W-1:0]   m_tdata,
    // singular
    output logic [0:0]                     m_tuser,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ssi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssi_pkg::V_W-1:0]        cfg_data
);
    localparam int V    = ssi_pkg::V_W;
    localparam int LAST = 19 + ssi_pkg::DIV_LAT;
    localparam int LW   = 1 + ssi_pkg::IDX_W + V;

    logic en;
    assign en = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // configuration
    ssi_pkg::val_t focal_reg, pixel_reg, cx_reg, cy_reg, cz_reg;
    logic [ssi_pkg::DIM_W-1:0] cols_reg, rows_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_reg <= '0;
            pixel_reg <= '0;
            cols_reg  <= ssi_pkg::DIM_W'(1);
            rows_reg  <= ssi_pkg::DIM_W'(1);
            cx_reg    <= '0;
            cy_reg    <= '0;
            cz_reg    <= '0;
        end else if (cfg_valid) begin
            case (ssi_pkg::cfg_reg_t'(cfg_index))
                ssi_pkg::REG_FOCAL: focal_reg <= cfg_data;
                ssi_pkg::REG_PIXEL: pixel_reg <= cfg_data;
                ssi_pkg::REG_COLS:  cols_reg  <= cfg_data[ssi_pkg::DIM_W-1:0];
                ssi_pkg::REG_ROWS:  rows_reg  <= cfg_data[ssi_pkg::DIM_W-1:0];
                ssi_pkg::REG_CX:    cx_reg    <= cfg_data;
                ssi_pkg::REG_CY:    cy_reg    <= cfg_data;
                ssi_pkg::REG_CZ:    cz_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits
    logic [LAST:0] vld_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAST-1:0], s_tvalid};
    end

    // stage 0: centring
    logic [ssi_pkg::DIM_W-1:0] cols_m1, rows_m1, half_c, half_r;
    logic [ssi_pkg::PIX_W-1:0] pix [4];
    logic [ssi_pkg::DIM_W-1:0] hsel [4];
    logic signed [ssi_pkg::CEN_W-1:0] c_next [4];
    logic signed [ssi_pkg::CEN_W-1:0] c_reg  [4];

    assign cols_m1 = cols_reg - ssi_pkg::DIM_W'(1);
    assign rows_m1 = rows_reg - ssi_pkg::DIM_W'(1);
    assign half_c  = (cols_reg == '0) ? '0 : {1'b0, cols_m1[ssi_pkg::DIM_W-1:1]};
    assign half_r  = (rows_reg == '0) ? '0 : {1'b0, rows_m1[ssi_pkg::DIM_W-1:1]};
    assign pix[0]  = s_tdata[ssi_pkg::OFF_LPX +: ssi_pkg::PIX_W];
    assign pix[1]  = s_tdata[ssi_pkg::OFF_LPY +: ssi_pkg::PIX_W];
    assign pix[2]  = s_tdata[ssi_pkg::OFF_RPX +: ssi_pkg::PIX_W];
    assign pix[3]  = s_tdata[ssi_pkg::OFF_RPY +: ssi_pkg::PIX_W];
    assign hsel[0] = half_c;
    assign hsel[1] = half_r;
    assign hsel[2] = half_c;
    assign hsel[3] = half_r;

    always_comb begin
        for (int i = 0; i < 4; i++)
            c_next[i] = {pix[i][ssi_pkg::PIX_W-1], pix[i]}
                      - {1'b0, hsel[i], {ssi_pkg::PIX_FRAC{1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++)
                c_reg[i] <= c_next[i];
        end
    end

    // load fields to stage 3, opcode on to the output
    logic [LW-1:0] ld_in, ld3;
    logic          op3, op_last;
    logic [ssi_pkg::IDX_W-1:0] idx3;
    ssi_pkg::val_t coef3;

    assign ld_in = {s_tuser[0], s_tdata[ssi_pkg::OFF_IDX +: ssi_pkg::IDX_W],
                    s_tdata[ssi_pkg::OFF_COEF +: V]};
    ssi_dly #(.W(LW), .N(4)) u_dly_ld (.aclk(aclk), .en(en), .d(ld_in), .q(ld3));
    assign op3   = ld3[LW-1];
    assign idx3  = ld3[V +: ssi_pkg::IDX_W];
    assign coef3 = ld3[V-1:0];
    ssi_dly #(.W(1), .N(LAST - 3)) u_dly_op (.aclk(aclk), .en(en), .d(op3), .q(op_last));

    // level 0: scale by pixel size
    ssi_pkg::prod_t p0 [4];
    ssi_pkg::val_t  x_reg [4];
    for (genvar gi = 0; gi < 4; gi++) begin : g_l0
        ssi_mul u_mul (.aclk(aclk), .en(en), .a(pixel_reg),
                       .b(ssi_pkg::val_t'(c_reg[gi])), .p(p0[gi]));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++)
                x_reg[i] <= ssi_pkg::rnd_sat(ssi_pkg::acc_t'(p0[i]), ssi_pkg::PIX_FRAC);
        end
    end

    // projection table, written by load items at stage 3
    ssi_pkg::val_t tbl_reg [ssi_pkg::TBL_DEPTH];
    always_ff @(posedge aclk) begin
        if (en && vld_reg[3] && (op3 == ssi_pkg::OP_LOAD)
                && (idx3 < ssi_pkg::IDX_W'(ssi_pkg::TBL_DEPTH)))
            tbl_reg[idx3] <= coef3;
    end

    // level 1: collinearity rows
    ssi_pkg::val_t  m1a [12];
    ssi_pkg::val_t  m1b [12];
    ssi_pkg::prod_t e_p [12];
    logic [8*V-1:0] tpk_in, tpk5;
    ssi_pkg::val_t  t5 [8];
    ssi_pkg::acc_t  sum1_next [10];
    ssi_pkg::acc_t  sum1_reg  [10];
    ssi_pkg::val_t  eq_reg    [10];

    always_comb begin
        m1a[0] = x_reg[0];  m1b[0] = cz_reg;
        m1a[1] = focal_reg; m1b[1] = cx_reg;
        m1a[2] = x_reg[1];  m1b[2] = cz_reg;
        m1a[3] = focal_reg; m1b[3] = cy_reg;
        for (int k = 0; k < 4; k++) begin
            m1a[4+k] = x_reg[2]; m1b[4+k] = tbl_reg[8+k];
            m1a[8+k] = x_reg[3]; m1b[8+k] = tbl_reg[8+k];
        end
        for (int k = 0; k < 8; k++)
            tpk_in[k*V +: V] = tbl_reg[k];
    end

    for (genvar gi = 0; gi < 12; gi++) begin : g_l1
        ssi_mul u_mul (.aclk(aclk), .en(en), .a(m1a[gi]), .b(m1b[gi]), .p(e_p[gi]));
    end

    ssi_dly #(.W(8*V), .N(2)) u_dly_t (.aclk(aclk), .en(en), .d(tpk_in), .q(tpk5));

    always_comb begin
        for (int k = 0; k < 8; k++)
            t5[k] = tpk5[k*V +: V];
        for (int k = 0; k < 3; k++) begin
            sum1_next[k]   = (ssi_pkg::acc_t'(t5[k]) <<< FRAC_BITS)
                           - ssi_pkg::acc_t'(e_p[4+k]);
            sum1_next[3+k] = (ssi_pkg::acc_t'(t5[4+k]) <<< FRAC_BITS)
                           - ssi_pkg::acc_t'(e_p[8+k]);
        end
        sum1_next[6] = ssi_pkg::acc_t'(e_p[0]) + ssi_pkg::acc_t'(e_p[1]);
        sum1_next[7] = ssi_pkg::acc_t'(e_p[2]) + ssi_pkg::acc_t'(e_p[3]);
        sum1_next[8] = ssi_pkg::acc_t'(e_p[7]) - (ssi_pkg::acc_t'(t5[3]) <<< FRAC_BITS);
        sum1_next[9] = ssi_pkg::acc_t'(e_p[11]) - (ssi_pkg::acc_t'(t5[7]) <<< FRAC_BITS);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 10; i++) begin
                sum1_reg[i] <= sum1_next[i];
                eq_reg[i]   <= ssi_pkg::rnd_sat(sum1_reg[i], FRAC_BITS);
            end
        end
    end

    // left centred coordinates, stage 3 to stage 7
    logic [2*V-1:0] xy_in, xy7;
    assign xy_in = {x_reg[1], x_reg[0]};
    ssi_dly #(.W(2*V), .N(4)) u_dly_xy (.aclk(aclk), .en(en), .d(xy_in), .q(xy7));

    // level 2: normal matrix and right-hand side
    ssi_pkg::val_t  a_m [4][3];
    ssi_pkg::val_t  l_m [4];
    ssi_pkg::prod_t np_p [36];
    ssi_pkg::prod_t gp_p [12];
    ssi_pkg::acc_t  nsum_next [9];
    ssi_pkg::acc_t  nsum_reg  [9];
    ssi_pkg::acc_t  gsum_next [3];
    ssi_pkg::acc_t  gsum_reg  [3];
    ssi_pkg::val_t  n_reg [9];
    ssi_pkg::val_t  g_reg [3];

    always_comb begin
        a_m[0][0] = focal_reg;  a_m[0][1] = '0;        a_m[0][2] = xy7[V-1:0];
        a_m[1][0] = '0;         a_m[1][1] = focal_reg; a_m[1][2] = xy7[2*V-1:V];
        for (int k = 0; k < 3; k++) begin
            a_m[2][k] = eq_reg[k];
            a_m[3][k] = eq_reg[3+k];
        end
        for (int r = 0; r < 4; r++)
            l_m[r] = eq_reg[6+r];
    end

    for (genvar gi = 0; gi < 3; gi++) begin : g_l2
        for (genvar gr = 0; gr < 4; gr++) begin : g_row
            for (genvar gk = 0; gk < 3; gk++) begin : g_n
                ssi_mul u_mul (.aclk(aclk), .en(en), .a(a_m[gr][gi]), .b(a_m[gr][gk]),
                               .p(np_p[(gi*3+gk)*4+gr]));
            end
            ssi_mul u_mul_g (.aclk(aclk), .en(en), .a(a_m[gr][gi]), .b(l_m[gr]),
                             .p(gp_p[gi*4+gr]));
        end
    end

    always_comb begin
        for (int j = 0; j < 9; j++) begin
            nsum_next[j] = '0;
            for (int r = 0; r < 4; r++)
                nsum_next[j] = nsum_next[j] + ssi_pkg::acc_t'(np_p[j*4+r]);
        end
        for (int j = 0; j < 3; j++) begin
            gsum_next[j] = '0;
            for (int r = 0; r < 4; r++)
                gsum_next[j] = gsum_next[j] + ssi_pkg::acc_t'(gp_p[j*4+r]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 9; j++) begin
                nsum_reg[j] <= nsum_next[j];
                n_reg[j]    <= ssi_pkg::rnd_sat(nsum_reg[j], FRAC_BITS);
            end
            for (int j = 0; j < 3; j++) begin
                gsum_reg[j] <= gsum_next[j];
                g_reg[j]    <= ssi_pkg::rnd_sat(gsum_reg[j], FRAC_BITS);
            end
        end
    end

    // level 3: cofactors
    ssi_pkg::prod_t cp_a [9];
    ssi_pkg::prod_t cp_b [9];
    ssi_pkg::acc_t  cdif_reg [9];
    ssi_pkg::val_t  cof_reg  [9];

    for (genvar gi = 0; gi < 3; gi++) begin : g_l3
        for (genvar gk = 0; gk < 3; gk++) begin : g_col
            localparam int I1 = (gi + 1) % 3;
            localparam int I2 = (gi + 2) % 3;
            localparam int K1 = (gk + 1) % 3;
            localparam int K2 = (gk + 2) % 3;
            ssi_mul u_mul_a (.aclk(aclk), .en(en), .a(n_reg[I1*3+K1]), .b(n_reg[I2*3+K2]),
                             .p(cp_a[gi*3+gk]));
            ssi_mul u_mul_b (.aclk(aclk), .en(en), .a(n_reg[I1*3+K2]), .b(n_reg[I2*3+K1]),
                             .p(cp_b[gi*3+gk]));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 9; j++) begin
                cdif_reg[j] <= ssi_pkg::acc_t'(cp_a[j]) - ssi_pkg::acc_t'(cp_b[j]);
                cof_reg[j]  <= ssi_pkg::rnd_sat(cdif_reg[j], FRAC_BITS);
            end
        end
    end

    // first normal row and right-hand side, stage 11 to stage 15
    logic [6*V-1:0] ng_in, ng15;
    ssi_pkg::val_t  n15 [3];
    ssi_pkg::val_t  g15 [3];
    assign ng_in = {g_reg[2], g_reg[1], g_reg[0], n_reg[2], n_reg[1], n_reg[0]};
    ssi_dly #(.W(6*V), .N(4)) u_dly_ng (.aclk(aclk), .en(en), .d(ng_in), .q(ng15));

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n15[k] = ng15[k*V +: V];
            g15[k] = ng15[(3+k)*V +: V];
        end
    end

    // level 4: determinant and solution numerators
    ssi_pkg::prod_t dp_p [3];
    ssi_pkg::prod_t qp_p [9];
    ssi_pkg::acc_t  dsum_next, dsum_reg;
    ssi_pkg::acc_t  qsum_next [3];
    ssi_pkg::acc_t  qsum_reg  [3];
    ssi_pkg::acc_t  numr_reg  [3];
    ssi_pkg::val_t  det_reg;

    for (genvar gk = 0; gk < 3; gk++) begin : g_det
        ssi_mul u_mul (.aclk(aclk), .en(en), .a(n15[gk]), .b(cof_reg[gk]), .p(dp_p[gk]));
    end
    for (genvar gi = 0; gi < 3; gi++) begin : g_num
        for (genvar gk = 0; gk < 3; gk++) begin : g_k
            ssi_mul u_mul (.aclk(aclk), .en(en), .a(cof_reg[gk*3+gi]), .b(g15[gk]),
                           .p(qp_p[gi*3+gk]));
        end
    end

    always_comb begin
        dsum_next = '0;
        for (int k = 0; k < 3; k++)
            dsum_next = dsum_next + ssi_pkg::acc_t'(dp_p[k]);
        for (int i = 0; i < 3; i++) begin
            qsum_next[i] = '0;
            for (int k = 0; k < 3; k++)
                qsum_next[i] = qsum_next[i] + ssi_pkg::acc_t'(qp_p[i*3+k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dsum_reg <= dsum_next;
            det_reg  <= ssi_pkg::rnd_sat(dsum_reg, FRAC_BITS);
            for (int i = 0; i < 3; i++) begin
                qsum_reg[i] <= qsum_next[i];
                numr_reg[i] <= qsum_reg[i];
            end
        end
    end

    // division
    ssi_pkg::val_t quo [3];
    logic          sing_in, sing_last;
    for (genvar gi = 0; gi < 3; gi++) begin : g_div
        ssi_div u_div (.aclk(aclk), .en(en), .num(numr_reg[gi]), .den(det_reg),
                       .quo(quo[gi]));
    end

    assign sing_in = (det_reg == '0);
    ssi_dly #(.W(1), .N(ssi_pkg::DIV_LAT)) u_dly_sing (
        .aclk(aclk), .en(en), .d(sing_in), .q(sing_last)
    );

    // output register
    logic                          m_tvalid_reg;
    logic [ssi_pkg::M_DATA_W-1:0]  m_tdata_reg;
    logic                          m_sing_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            m_tvalid_reg <= 1'b0;
        else if (en)
            m_tvalid_reg <= vld_reg[LAST] && (op_last == ssi_pkg::OP_SOLVE);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_sing_reg  <= sing_last;
            m_tdata_reg <= sing_last ? '0 : {quo[2], quo[1], quo[0]};
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_sing_reg;
endmodule

### hw/rtl/ssi_checker.sv
// Port-level checks for stereo_space_intersection, bound to the top level.
// Depends on ssi_pkg.
`timescale 1ns / 1ps

module ssi_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ssi_pkg::M_DATA_W-1:0]  m_tdata,
    input logic [0:0]                    m_tuser
);
    // the input side only stalls while a result is held
    a_ready_link: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output stall");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("held result changed before transfer");

    a_singular_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("singular result carries nonzero coordinates");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");
endmodule

bind stereo_space_intersection ssi_checker u_ssi_checker (.*);
